/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console cell writer package
// Field widths, stream packing, action codes and control characters shared
// by the console modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int TCOL_W   = 7;
    localparam int TROW_W   = 5;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = ACTION_W;
    localparam int M_TDATA_W = 32;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT_CHAR  = 2'd0,
        ACT_GOTO_XY   = 2'd1,
        ACT_CLEAR     = 2'd2,
        ACT_READ_CELL = 2'd3
    } action_t;

endpackage

/* rtl/text_console_cell_writer.sv */
// ----------------------------------------------------------------------------
// Text console cell writer
// Character and attribute screen with a cursor, newline, return, backspace,
// scrolling through a row ring, cursor positioning, screen clear and reads.
// ----------------------------------------------------------------------------
// Each input transaction yields one result transaction carrying the cursor
// after the action. Cursor-only actions (newline without scroll, return,
// backspace, goto) need no memory access; a character write or cell read
// passes through the two-stage address unit and the single memory port.
// A scroll clears one cell per cycle through the same address unit and
// port, and a screen clear walks every cell the same way. After reset the
// block clears the cell memory before s_tready rises; the attribute
// register is writable at any time and should only be changed while the
// block is idle.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // char_code [7:0], target_col [14:8], target_row [19:15], zero fill above
    input  logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata,
    // action [1:0]
    input  logic [tcw_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cursor_row [4:0], cursor_col [11:5], cell_char [19:12], cell_attr [27:20],
    // scrolled [28], position_ok [29], zero fill above
    output logic [tcw_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]      cfg_data
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_DRAIN,
        ST_IDLE,
        ST_ACCESS,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE_CHAR,
        OP_WRITE_ZERO
    } mem_op_t;

    state_t  state_reg, state_next;
    mem_op_t op_reg, op_next;

    logic [RW-1:0] cursor_row_reg, cursor_row_next;
    logic [CW-1:0] cursor_col_reg, cursor_col_next;
    logic [RW-1:0] top_reg, top_next;
    logic [tcw_pkg::ATTR_W-1:0] attr_reg;

    logic [RW-1:0] sw_row_reg, sw_row_next;
    logic [CW-1:0] sw_col_reg, sw_col_next;
    logic [RW-1:0] sw_last_reg, sw_last_next;

    logic need_scroll_reg, need_scroll_next;
    logic pending_reg, pending_next;
    logic scrolled_reg, scrolled_next;
    logic ok_reg, ok_next;
    logic use_rd_reg, use_rd_next;
    logic m_tvalid_reg, m_tvalid_next;

    logic [tcw_pkg::CELL_W-1:0]    wdata_reg, wdata_next;
    logic [tcw_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic          u_valid;
    logic [RW-1:0] u_row;
    logic [CW-1:0] u_col;
    logic [RW-1:0] u_off;
    logic          u_out_valid;
    logic [AW-1:0] u_out_addr;
    logic          u_busy;

    logic                       mem_en;
    logic                       mem_we;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    tcw_pkg::action_t             act;
    logic [tcw_pkg::CHAR_W-1:0]   code;
    logic [tcw_pkg::TCOL_W-1:0]   tcol;
    logic [tcw_pkg::TROW_W-1:0]   trow;
    logic                         in_range;
    logic [tcw_pkg::CHAR_W-1:0]   res_char;
    logic [tcw_pkg::ATTR_W-1:0]   res_attr;

    assign act  = tcw_pkg::action_t'(s_tuser);
    assign code = s_tdata[7:0];
    assign tcol = s_tdata[14:8];
    assign trow = s_tdata[19:15];
    assign in_range = (tcol != '0) && (int'(tcol) <= COLUMNS) &&
                      (trow != '0) && (int'(trow) <= ROWS);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign mem_en    = u_out_valid;
    assign mem_we    = u_out_valid && (op_reg != OP_READ);
    assign mem_wdata = (op_reg == OP_WRITE_ZERO) ? '0 : wdata_reg;

    assign res_char = use_rd_reg ? mem_rdata[7:0]  : '0;
    assign res_attr = use_rd_reg ? mem_rdata[15:8] : '0;

    tcw_addr_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (u_valid),
        .in_row    (u_row),
        .in_col    (u_col),
        .in_offset (u_off),
        .out_valid (u_out_valid),
        .out_addr  (u_out_addr),
        .busy      (u_busy)
    );

    tcw_cell_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (u_out_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        cursor_row_next  = cursor_row_reg;
        cursor_col_next  = cursor_col_reg;
        top_next         = top_reg;
        sw_row_next      = sw_row_reg;
        sw_col_next      = sw_col_reg;
        sw_last_next     = sw_last_reg;
        need_scroll_next = need_scroll_reg;
        pending_next     = pending_reg;
        scrolled_next    = scrolled_reg;
        ok_next          = ok_reg;
        use_rd_next      = use_rd_reg;
        wdata_next       = wdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        u_valid          = 1'b0;
        u_row            = '0;
        u_col            = '0;
        u_off            = '0;

        unique case (state_reg)
            ST_SWEEP: begin
                u_valid = 1'b1;
                u_row   = sw_row_reg;
                u_col   = sw_col_reg;
                if (sw_col_reg == LAST_COL) begin
                    sw_col_next = '0;
                    if (sw_row_reg == sw_last_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        sw_row_next = sw_row_reg + RW'(1);
                    end
                end else begin
                    sw_col_next = sw_col_reg + CW'(1);
                end
            end

            ST_DRAIN: begin
                if (!u_busy) begin
                    state_next = pending_reg ? ST_FINISH : ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    pending_next     = 1'b1;
                    scrolled_next    = 1'b0;
                    ok_next          = 1'b1;
                    use_rd_next      = 1'b0;
                    need_scroll_next = 1'b0;
                    state_next       = ST_FINISH;
                    unique case (act)
                        tcw_pkg::ACT_PUT_CHAR: begin
                            priority if (code == tcw_pkg::CODE_NEWLINE) begin
                                if (cursor_row_reg == LAST_ROW) begin
                                    sw_row_next   = top_reg;
                                    sw_col_next   = '0;
                                    sw_last_next  = top_reg;
                                    top_next      = (top_reg == LAST_ROW) ? '0
                                                    : top_reg + RW'(1);
                                    op_next       = OP_WRITE_ZERO;
                                    scrolled_next = 1'b1;
                                    state_next    = ST_SWEEP;
                                end else begin
                                    cursor_row_next = cursor_row_reg + RW'(1);
                                end
                            end else if (code == tcw_pkg::CODE_RETURN) begin
                                cursor_col_next = '0;
                            end else if (code == tcw_pkg::CODE_BACKSPACE) begin
                                if (cursor_col_reg != '0) begin
                                    cursor_col_next = cursor_col_reg - CW'(1);
                                end else if (cursor_row_reg != '0) begin
                                    cursor_row_next = cursor_row_reg - RW'(1);
                                    cursor_col_next = LAST_COL;
                                end
                            end else begin
                                u_valid    = 1'b1;
                                u_row      = cursor_row_reg;
                                u_col      = cursor_col_reg;
                                u_off      = top_reg;
                                op_next    = OP_WRITE_CHAR;
                                wdata_next = {attr_reg, code};
                                state_next = ST_ACCESS;
                                if (cursor_col_reg == LAST_COL) begin
                                    cursor_col_next = '0;
                                    if (cursor_row_reg == LAST_ROW) begin
                                        need_scroll_next = 1'b1;
                                    end else begin
                                        cursor_row_next = cursor_row_reg + RW'(1);
                                    end
                                end else begin
                                    cursor_col_next = cursor_col_reg + CW'(1);
                                end
                            end
                        end
                        tcw_pkg::ACT_GOTO_XY: begin
                            if (in_range) begin
                                cursor_col_next = CW'(tcol - tcw_pkg::TCOL_W'(1));
                                cursor_row_next = RW'(trow - tcw_pkg::TROW_W'(1));
                            end else begin
                                ok_next = 1'b0;
                            end
                        end
                        tcw_pkg::ACT_CLEAR: begin
                            sw_row_next  = '0;
                            sw_col_next  = '0;
                            sw_last_next = LAST_ROW;
                            top_next     = '0;
                            op_next      = OP_WRITE_ZERO;
                            state_next   = ST_SWEEP;
                        end
                        tcw_pkg::ACT_READ_CELL: begin
                            if (in_range) begin
                                u_valid     = 1'b1;
                                u_row       = RW'(trow - tcw_pkg::TROW_W'(1));
                                u_col       = CW'(tcol - tcw_pkg::TCOL_W'(1));
                                u_off       = top_reg;
                                op_next     = OP_READ;
                                use_rd_next = 1'b1;
                                state_next  = ST_ACCESS;
                            end else begin
                                ok_next = 1'b0;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_ACCESS: begin
                if (u_out_valid) begin
                    if (need_scroll_reg) begin
                        need_scroll_next = 1'b0;
                        sw_row_next      = top_reg;
                        sw_col_next      = '0;
                        sw_last_next     = top_reg;
                        top_next         = (top_reg == LAST_ROW) ? '0 : top_reg + RW'(1);
                        op_next          = OP_WRITE_ZERO;
                        scrolled_next    = 1'b1;
                        state_next       = ST_SWEEP;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, ok_reg, scrolled_reg, res_attr, res_char,
                                     tcw_pkg::COL_W'(cursor_col_reg),
                                     tcw_pkg::ROW_W'(cursor_row_reg)};
                    pending_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_SWEEP;
            op_reg          <= OP_WRITE_ZERO;
            cursor_row_reg  <= '0;
            cursor_col_reg  <= '0;
            top_reg         <= '0;
            attr_reg        <= tcw_pkg::ATTR_RESET;
            sw_row_reg      <= '0;
            sw_col_reg      <= '0;
            sw_last_reg     <= LAST_ROW;
            need_scroll_reg <= 1'b0;
            pending_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            cursor_row_reg  <= cursor_row_next;
            cursor_col_reg  <= cursor_col_next;
            top_reg         <= top_next;
            if (cfg_valid && cfg_ready) begin
                attr_reg <= cfg_data;
            end
            sw_row_reg      <= sw_row_next;
            sw_col_reg      <= sw_col_next;
            sw_last_reg     <= sw_last_next;
            need_scroll_reg <= need_scroll_next;
            pending_reg     <= pending_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scrolled_reg <= scrolled_next;
        ok_reg       <= ok_next;
        use_rd_reg   <= use_rd_next;
        wdata_reg    <= wdata_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !u_busy)
        else $error("Address unit busy while accepting a transaction.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_en)
        else $error("Cell memory accessed while idle.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Ready did not drop after an accepted transaction.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(cursor_row_reg) < ROWS) && (int'(cursor_col_reg) < COLUMNS) &&
        (int'(top_reg) < ROWS))
        else $error("Cursor or ring offset out of range.");

endmodule

/* rtl/tcw_addr_unit.sv */
// ----------------------------------------------------------------------------
// Cell address unit
// Two-stage pipeline that maps a screen row and column to a linear cell
// address: the row is rotated by the ring offset, then scaled by the row
// length and added to the column. Shared by cell writes, reads and walks.
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    input  logic [$clog2(ROWS)-1:0]            in_row,
    input  logic [$clog2(COLUMNS)-1:0]         in_col,
    input  logic [$clog2(ROWS)-1:0]            in_offset,
    output logic                               out_valid,
    output logic [$clog2(ROWS*COLUMNS)-1:0]    out_addr,
    output logic                               busy
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int AW = $clog2(ROWS * COLUMNS);

    logic          v1_reg;
    logic [RW-1:0] phys1_reg;
    logic [CW-1:0] col1_reg;
    logic          v2_reg;
    logic [AW-1:0] addr2_reg;

    logic [RW:0]   row_sum;
    logic [RW-1:0] phys_next;
    logic [AW-1:0] addr_next;

    always_comb begin
        row_sum = {1'b0, in_row} + {1'b0, in_offset};
        if (row_sum >= (RW+1)'(ROWS)) begin
            phys_next = RW'(row_sum - (RW+1)'(ROWS));
        end else begin
            phys_next = RW'(row_sum);
        end
        addr_next = AW'(phys1_reg) * AW'(COLUMNS) + AW'(col1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        phys1_reg <= phys_next;
        col1_reg  <= in_col;
        addr2_reg <= addr_next;
    end

    assign out_valid = v2_reg;
    assign out_addr  = addr2_reg;
    assign busy      = v1_reg | v2_reg;

endmodule

/* rtl/tcw_cell_mem.sv */
// ----------------------------------------------------------------------------
// Cell memory
// Single-port store of character and attribute cells with registered read.
// ----------------------------------------------------------------------------
module tcw_cell_mem #(
    parameter int DEPTH = 2000
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     addr,
    input  logic [tcw_pkg::CELL_W-1:0]   wdata,
    output logic [tcw_pkg::CELL_W-1:0]   rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
